// ===== sv/gpa_pkg.sv =====
package gpa_pkg;

  localparam int DW = 32;
  localparam int VW = 42;
  localparam int ZW = 26;
  localparam int TABLE_LEN = 24;
  localparam logic signed [ZW-1:0] DEG180_Q16 = 26'sd11796480;
  localparam logic [21:0] KINV_Q22 = 22'd2547003;
  localparam int PITCH_LIMIT = 23040;
  localparam int YAW_LIMIT = 46080;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 bypass;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] t;
    begin
      case (i)
        0: t = 26'sd2949120;
        1: t = 26'sd1740967;
        2: t = 26'sd919879;
        3: t = 26'sd466945;
        4: t = 26'sd234379;
        5: t = 26'sd117304;
        6: t = 26'sd58666;
        7: t = 26'sd29335;
        8: t = 26'sd14668;
        9: t = 26'sd7334;
        10: t = 26'sd3667;
        11: t = 26'sd1833;
        12: t = 26'sd917;
        13: t = 26'sd458;
        14: t = 26'sd229;
        15: t = 26'sd115;
        16: t = 26'sd57;
        17: t = 26'sd29;
        18: t = 26'sd14;
        19: t = 26'sd7;
        20: t = 26'sd4;
        21: t = 26'sd2;
        22: t = 26'sd1;
        default: t = '0;
      endcase
      return t;
    end
  endfunction

endpackage

// ===== sv/gpa_cell.sv =====
module gpa_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             en,
  input  gpa_pkg::cordic_t din,
  output gpa_pkg::cordic_t dout
);
  import gpa_pkg::*;

  logic signed [VW-1:0] xs, ys;

  assign xs = din.x >>> STEP;
  assign ys = din.y >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      dout.bypass <= din.bypass;
      if (din.bypass || STEP >= TABLE_LEN) begin
        dout.x <= din.x;
        dout.y <= din.y;
        dout.z <= din.z;
      end else if (din.y < 0) begin
        dout.x <= din.x - ys;
        dout.y <= din.y + xs;
        dout.z <= din.z - atan_q16(STEP);
      end else begin
        dout.x <= din.x + ys;
        dout.y <= din.y - xs;
        dout.z <= din.z + atan_q16(STEP);
      end
    end
  end

endmodule

// ===== sv/gpa_chain.sv =====
module gpa_chain #(
  parameter int ITERATIONS = 16
) (
  input  logic             clk,
  input  logic             en,
  input  gpa_pkg::cordic_t din,
  output gpa_pkg::cordic_t dout
);
  import gpa_pkg::*;

  cordic_t link [ITERATIONS+1];

  assign link[0] = din;
  assign dout = link[ITERATIONS];

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    gpa_cell #(.STEP(i)) u_cell (
      .clk(clk), .en(en), .din(link[i]), .dout(link[i+1])
    );
  end

endmodule

// ===== sv/gimbal_pointing_angles.sv =====
// pipeline order: differences, yaw fold, yaw chain, gain multiply, pitch fold, pitch chain, output register
// throughput: one word per cycle while not stalled; two chains of CORDIC_ITERATIONS cells (yaw, then pitch)
// all stages advance together whenever the output register is free or being taken
// reset: clears the valid bits of every stage; payload registers are not reset
module gimbal_pointing_angles #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [30:0]  target_x,
  input  logic signed [30:0]  target_y,
  input  logic signed [30:0]  target_z,
  input  logic signed [30:0]  vehicle_x,
  input  logic signed [30:0]  vehicle_y,
  input  logic signed [30:0]  vehicle_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  pitch_angle,
  output logic signed [16:0]  yaw_angle
);
  import gpa_pkg::*;

  localparam int LAT = 2 * CORDIC_ITERATIONS + 6;

  logic en;
  logic [LAT-1:0] vld;

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // stage 1: differences, guard scaled
  logic signed [VW-1:0] dx1, dy1, dz1;
  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= VW'(signed'(DW'(target_x) - DW'(vehicle_x))) <<< 8;
      dy1 <= VW'(signed'(DW'(target_y) - DW'(vehicle_y))) <<< 8;
      dz1 <= VW'(signed'(DW'(target_z) - DW'(vehicle_z))) <<< 8;
    end
  end

  // stage 2: quadrant fold for yaw
  cordic_t ya_in, ya_out;
  logic signed [VW-1:0] dzy [CORDIC_ITERATIONS+1];
  logic [CORDIC_ITERATIONS:0] dxz_d, dyz_d;
  logic signed [VW-1:0] axy_d [CORDIC_ITERATIONS+1];
  logic ysp;
  always_ff @(posedge clk) begin
    if (en) begin
      ya_in.bypass <= (dy1 == 0);
      ya_in.x <= (dx1 < 0) ? -dx1 : dx1;
      ya_in.y <= (dx1 < 0) ? -dy1 : dy1;
      if (dy1 == 0)
        ya_in.z <= (dx1 < 0) ? DEG180_Q16 : '0;
      else if (dx1 < 0)
        ya_in.z <= (dy1 >= 0) ? DEG180_Q16 : -DEG180_Q16;
      else
        ya_in.z <= '0;
      dzy[0] <= dz1;
      dxz_d[0] <= (dx1 == 0);
      dyz_d[0] <= (dy1 == 0);
      axy_d[0] <= (dx1 == 0) ? ((dy1 < 0) ? -dy1 : dy1) : ((dx1 < 0) ? -dx1 : dx1);
    end
  end

  // delay line for dx, dy zero flags, the axis magnitude and dz alongside yaw chain
  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        dxz_d[i+1] <= dxz_d[i];
        dyz_d[i+1] <= dyz_d[i];
        axy_d[i+1] <= axy_d[i];
        dzy[i+1] <= dzy[i];
      end
    end
  end
  assign ysp = 1'b0;

  gpa_chain #(.ITERATIONS(CORDIC_ITERATIONS)) u_yaw (
    .clk(clk), .en(en), .din(ya_in), .dout(ya_out)
  );

  // stages 3 and 4: gain correction multiply, split in a 32-bit and a 10-bit partial product
  logic signed [VW-1:0] mag3, ax3, dz3;
  logic dxz3, dyz3;
  logic signed [ZW-1:0] yz3;
  logic [53:0] plo4, phi4;
  logic signed [VW-1:0] ax4, dz4, mag4;
  logic dxz4, dyz4, magz4;
  logic signed [ZW-1:0] yz4;
  always_ff @(posedge clk) begin
    if (en) begin
      mag3 <= ya_out.x;
      yz3 <= ya_out.z;
      ax3 <= axy_d[CORDIC_ITERATIONS];
      dz3 <= dzy[CORDIC_ITERATIONS];
      dxz3 <= dxz_d[CORDIC_ITERATIONS] | ysp;
      dyz3 <= dyz_d[CORDIC_ITERATIONS];
      plo4 <= 54'(mag3[31:0]) * 54'(KINV_Q22);
      phi4 <= 54'(mag3[VW-1:32]) * 54'(KINV_Q22);
      ax4 <= ax3;
      dz4 <= dz3;
      mag4 <= mag3;
      dxz4 <= dxz3;
      dyz4 <= dyz3;
      magz4 <= (mag3 == 0);
      yz4 <= yz3;
    end
  end

  // stage 5: horizontal distance select and pitch fold
  logic [65:0] prod;
  logic signed [VW-1:0] r5;
  assign prod = 66'(plo4) + (66'(phi4) << 32) + (66'd1 << 21);
  always_comb begin
    if (magz4 || (dxz4 && dyz4))
      r5 = (!dxz4 && !dyz4) ? '0 : ax4;
    else if (dyz4)
      r5 = mag4;
    else
      r5 = VW'(prod >> 22);
  end

  cordic_t pa_in, pa_out;
  logic signed [ZW-1:0] yzp [CORDIC_ITERATIONS+1];
  always_ff @(posedge clk) begin
    if (en) begin
      pa_in.bypass <= (dz4 == 0);
      pa_in.x <= (r5 < 0) ? -r5 : r5;
      pa_in.y <= (r5 < 0) ? -dz4 : dz4;
      if (dz4 == 0)
        pa_in.z <= '0;
      else if (r5 < 0)
        pa_in.z <= (dz4 >= 0) ? DEG180_Q16 : -DEG180_Q16;
      else
        pa_in.z <= '0;
      yzp[0] <= yz4;
    end
  end
  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_ydly
    always_ff @(posedge clk) begin
      if (en) yzp[i+1] <= yzp[i];
    end
  end

  gpa_chain #(.ITERATIONS(CORDIC_ITERATIONS)) u_pitch (
    .clk(clk), .en(en), .din(pa_in), .dout(pa_out)
  );

  // final stage: round to q8, saturate, negate yaw
  logic signed [ZW-1:0] pr, yr;
  assign pr = (pa_out.z + ZW'(128)) >>> 8;
  assign yr = (yzp[CORDIC_ITERATIONS] + ZW'(128)) >>> 8;
  always_ff @(posedge clk) begin
    if (en) begin
      if (pr > ZW'(PITCH_LIMIT)) pitch_angle <= 16'(PITCH_LIMIT);
      else if (pr < -ZW'(PITCH_LIMIT)) pitch_angle <= -16'(PITCH_LIMIT);
      else pitch_angle <= 16'(pr);
      if (yr > ZW'(YAW_LIMIT)) yaw_angle <= -17'(YAW_LIMIT);
      else if (yr < -ZW'(YAW_LIMIT)) yaw_angle <= 17'(YAW_LIMIT);
      else yaw_angle <= 17'(-yr);
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(yaw_angle) && $stable(pitch_angle))
    else $error("result changed while stalled");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pitch_angle <= 16'sd23040 && pitch_angle >= -16'sd23040)
    else $error("pitch out of range");

endmodule
